// ===== rtl/ils_pkg.sv =====
package ils_pkg;

  localparam int MAX_N_DEF     = 8;
  localparam int FRAC_BITS_DEF = 16;
  localparam int OUT_LIMIT     = 8;
  localparam int DIV_STEPS     = 64;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_SOLVE  = 2'd2;

  localparam logic [1:0] CFG_SIZE   = 2'd0;
  localparam logic [1:0] CFG_TOL    = 2'd1;
  localparam logic [1:0] CFG_METHOD = 2'd2;
  localparam logic [1:0] CFG_MAXIT  = 2'd3;

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_LIMIT     = 2'd1;
  localparam logic [1:0] ST_ZERO_DIAG = 2'd2;

  localparam logic [3:0]  SIZE_RST  = 4'd4;
  localparam logic [30:0] TOL_RST   = 31'd7;
  localparam logic [7:0]  MAXIT_RST = 8'd100;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIAG,
    S_DCHK,
    S_ROW,
    S_DRAIN,
    S_DIV,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  // a - b, clamped to +-(2^63-1)
  function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s > 65'(S64_MAX)) begin
      sat_sub64 = S64_MAX;
    end else if (s < -65'(S64_MAX)) begin
      sat_sub64 = -S64_MAX;
    end else begin
      sat_sub64 = s[63:0];
    end
  endfunction

endpackage

// ===== rtl/iterative_linear_solver.sv =====
// Iterative linear solver, Jacobi or Gauss-Seidel, signed fixed point.
// Input stream: in_tuser carries the command (load coefficient, load
// right-hand side, solve); in_tdata carries row, col and value. Loads are
// taken one per cycle while idle and give no output. A solve clears the
// estimate and checks the diagonal, emitting at once on a zero entry, then
// runs sweeps until the largest change is within tolerance or
// max_iterations sweeps have run. Each row of a sweep reads the memories
// and runs the MAC, then a bit-serial divide; the divider sets the pace.
// Results: n items, one per unknown; out_tuser holds the status and
// out_tlast marks the final unknown. A stalled receiver holds the output
// register and the emit sequence waits on it.
// in_tready is high only while no solve is in progress.
// Reset restores the configuration defaults; matrix and right-hand-side
// memories keep their contents and must be loaded before a solve.
// The user writes configuration via cfg_we/cfg_addr/cfg_wdata while idle; not enforced.
module iterative_linear_solver #(
  parameter int MAX_N     = ils_pkg::MAX_N_DEF,
  parameter int FRAC_BITS = ils_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // row[2:0], col[5:3], value[37:6], zero fill
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // index[2:0], solution[34:3], sweeps[42:35], zero fill
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [30:0] cfg_wdata
);

  localparam int IW   = $clog2(MAX_N);
  localparam int CAW  = $clog2(MAX_N * MAX_N);
  localparam int EAW  = $clog2(2 * MAX_N);
  localparam int NLIM = (MAX_N < ils_pkg::OUT_LIMIT) ? MAX_N : ils_pkg::OUT_LIMIT;

  ils_pkg::state_t state_r, state_nxt;

  logic [3:0]  size_r;
  logic [30:0] tol_r;
  logic        meth_r;
  logic [7:0]  maxit_r;

  logic [IW-1:0] last_r, last_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic          bank_r, bank_nxt;
  logic [7:0]    sweeps_r, sweeps_nxt;
  logic [31:0]   big_r, big_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          zero_r, zero_nxt;
  logic          rd_v_r, rd_v_nxt;
  logic [IW-1:0] rd_j_r, rd_j_nxt;
  logic          mul_v_r, mul_v_nxt;
  logic signed [63:0] mul_r, mul_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [31:0] dvs_r, dvs_nxt;
  logic signed [31:0] xold_r, xold_nxt;
  logic [2*MAX_N-1:0] est_vld_r, est_vld_nxt;
  logic          est_vq_r;

  logic          out_v_r, out_v_nxt;
  logic [2:0]    out_idx_r, out_idx_nxt;
  logic [31:0]   out_sol_r, out_sol_nxt;
  logic [1:0]    out_st_r, out_st_nxt;
  logic [7:0]    out_sw_r, out_sw_nxt;
  logic          out_last_r, out_last_nxt;

  logic [2:0]  in_row, in_col;
  logic [31:0] in_value;
  logic        in_acc;

  logic           coef_we;
  logic [CAW-1:0] coef_waddr, coef_raddr;
  logic [31:0]    coef_q;
  logic           rhs_we;
  logic [IW-1:0]  rhs_waddr;
  logic [31:0]    rhs_q;
  logic           est_we;
  logic [EAW-1:0] est_waddr, est_raddr;
  logic [31:0]    est_q;
  logic signed [31:0] x_val;

  logic               div_start, div_done;
  logic signed [31:0] div_q;

  logic [3:0]  n0, n_eff;
  logic signed [32:0] diff;
  logic [31:0] mag, big_new;
  logic        dst_bank;
  logic [7:0]  sw_inc;

  assign in_row   = in_tdata[2:0];
  assign in_col   = in_tdata[5:3];
  assign in_value = in_tdata[37:6];
  assign in_acc   = in_tvalid && in_tready;
  assign in_tready = (state_r == ils_pkg::S_IDLE);

  assign n0    = (size_r == 4'd0) ? 4'd1 : size_r;
  assign n_eff = (n0 > 4'(NLIM)) ? 4'(NLIM) : n0;

  assign coef_we    = in_acc && (in_tuser == ils_pkg::CMD_LOAD_A)
                      && (32'(in_row) < 32'(MAX_N)) && (32'(in_col) < 32'(MAX_N));
  assign coef_waddr = CAW'(in_row) * CAW'(MAX_N) + CAW'(in_col);
  assign rhs_we     = in_acc && (in_tuser == ils_pkg::CMD_LOAD_B)
                      && (32'(in_row) < 32'(MAX_N));
  assign rhs_waddr  = IW'(in_row);

  assign dst_bank  = meth_r ? bank_r : ~bank_r;
  assign est_we    = (state_r == ils_pkg::S_DIV) && div_done;
  assign est_waddr = EAW'(dst_bank) * EAW'(MAX_N) + EAW'(i_r);
  assign x_val     = est_vq_r ? est_q : 32'sd0;

  assign diff    = {div_q[31], div_q} - {xold_r[31], xold_r};
  assign mag     = diff[32] ? 32'(-diff) : diff[31:0];
  assign big_new = (mag > big_r) ? mag : big_r;
  assign sw_inc  = sweeps_r + 8'd1;

  always_comb begin
    coef_raddr = CAW'(i_r) * CAW'(MAX_N) + CAW'(j_r);
    est_raddr  = EAW'(bank_r) * EAW'(MAX_N) + EAW'(j_r);
    case (state_r)
      ils_pkg::S_DIAG:    coef_raddr = CAW'(j_r) * CAW'(MAX_N) + CAW'(j_r);
      ils_pkg::S_EMIT_RD: est_raddr  = EAW'(bank_r) * EAW'(MAX_N) + EAW'(i_r);
      default: ;
    endcase
  end

  ils_ram #(.DEPTH(MAX_N * MAX_N), .WIDTH(32)) u_coef (
    .clk(clk), .we(coef_we), .waddr(coef_waddr), .wdata(in_value),
    .raddr(coef_raddr), .rdata(coef_q)
  );

  ils_ram #(.DEPTH(MAX_N), .WIDTH(32)) u_rhs (
    .clk(clk), .we(rhs_we), .waddr(rhs_waddr), .wdata(in_value),
    .raddr(i_r), .rdata(rhs_q)
  );

  ils_ram #(.DEPTH(2 * MAX_N), .WIDTH(32)) u_est (
    .clk(clk), .we(est_we), .waddr(est_waddr), .wdata(div_q),
    .raddr(est_raddr), .rdata(est_q)
  );

  ils_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(acc_r),
    .divisor(dvs_r), .done(div_done), .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ils_pkg::S_IDLE;
      size_r    <= ils_pkg::SIZE_RST;
      tol_r     <= ils_pkg::TOL_RST;
      meth_r    <= 1'b0;
      maxit_r   <= ils_pkg::MAXIT_RST;
      rd_v_r    <= 1'b0;
      mul_v_r   <= 1'b0;
      out_v_r   <= 1'b0;
      est_vld_r <= '0;
      sweeps_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_v_r    <= rd_v_nxt;
      mul_v_r   <= mul_v_nxt;
      out_v_r   <= out_v_nxt;
      est_vld_r <= est_vld_nxt;
      sweeps_r  <= sweeps_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          ils_pkg::CFG_SIZE:   size_r  <= cfg_wdata[3:0];
          ils_pkg::CFG_TOL:    tol_r   <= cfg_wdata;
          ils_pkg::CFG_METHOD: meth_r  <= cfg_wdata[0];
          ils_pkg::CFG_MAXIT:  maxit_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
    last_r     <= last_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    bank_r     <= bank_nxt;
    big_r      <= big_nxt;
    status_r   <= status_nxt;
    zero_r     <= zero_nxt;
    rd_j_r     <= rd_j_nxt;
    mul_r      <= mul_nxt;
    acc_r      <= acc_nxt;
    dvs_r      <= dvs_nxt;
    xold_r     <= xold_nxt;
    est_vq_r   <= est_vld_r[est_raddr];
    out_idx_r  <= out_idx_nxt;
    out_sol_r  <= out_sol_nxt;
    out_st_r   <= out_st_nxt;
    out_sw_r   <= out_sw_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    last_nxt     = last_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    bank_nxt     = bank_r;
    sweeps_nxt   = sweeps_r;
    big_nxt      = big_r;
    status_nxt   = status_r;
    zero_nxt     = zero_r;
    rd_v_nxt     = 1'b0;
    rd_j_nxt     = j_r;
    mul_v_nxt    = 1'b0;
    mul_nxt      = mul_r;
    acc_nxt      = acc_r;
    dvs_nxt      = dvs_r;
    xold_nxt     = xold_r;
    est_vld_nxt  = est_vld_r;
    div_start    = 1'b0;
    out_v_nxt    = (out_v_r && out_tready) ? 1'b0 : out_v_r;
    out_idx_nxt  = out_idx_r;
    out_sol_nxt  = out_sol_r;
    out_st_nxt   = out_st_r;
    out_sw_nxt   = out_sw_r;
    out_last_nxt = out_last_r;

    // read data stage: diagonal check, or multiply and capture of divisor and right-hand side
    if (rd_v_r) begin
      if (state_r == ils_pkg::S_DIAG || state_r == ils_pkg::S_DCHK) begin
        if (coef_q == 32'd0) begin
          zero_nxt = 1'b1;
        end
      end else begin
        if (rd_j_r == '0) begin
          acc_nxt = 64'(signed'(rhs_q)) <<< FRAC_BITS;
        end
        if (rd_j_r == i_r) begin
          dvs_nxt  = coef_q;
          xold_nxt = x_val;
        end else begin
          mul_nxt   = signed'(coef_q) * x_val;
          mul_v_nxt = 1'b1;
        end
      end
    end
    if (mul_v_r) begin
      acc_nxt = ils_pkg::sat_sub64(acc_r, mul_r);
    end

    case (state_r)
      ils_pkg::S_IDLE: begin
        if (in_acc && in_tuser == ils_pkg::CMD_SOLVE) begin
          last_nxt    = IW'(n_eff - 4'd1);
          est_vld_nxt = '0;
          sweeps_nxt  = '0;
          bank_nxt    = 1'b0;
          zero_nxt    = 1'b0;
          j_nxt       = '0;
          state_nxt   = ils_pkg::S_DIAG;
        end
      end
      ils_pkg::S_DIAG: begin
        rd_v_nxt = 1'b1;
        if (j_r == last_r) begin
          state_nxt = ils_pkg::S_DCHK;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ils_pkg::S_DCHK: begin
        i_nxt   = '0;
        j_nxt   = '0;
        big_nxt = '0;
        if (zero_nxt) begin
          status_nxt = ils_pkg::ST_ZERO_DIAG;
          state_nxt  = ils_pkg::S_EMIT_RD;
        end else if (maxit_r == 8'd0) begin
          status_nxt = ils_pkg::ST_LIMIT;
          state_nxt  = ils_pkg::S_EMIT_RD;
        end else begin
          state_nxt = ils_pkg::S_ROW;
        end
      end
      ils_pkg::S_ROW: begin
        rd_v_nxt = 1'b1;
        if (j_r == last_r) begin
          state_nxt = ils_pkg::S_DRAIN;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ils_pkg::S_DRAIN: begin
        if (!rd_v_r && !mul_v_r) begin
          div_start = 1'b1;
          state_nxt = ils_pkg::S_DIV;
        end
      end
      ils_pkg::S_DIV: begin
        if (div_done) begin
          est_vld_nxt[est_waddr] = 1'b1;
          big_nxt = big_new;
          j_nxt   = '0;
          if (i_r == last_r) begin
            sweeps_nxt = sw_inc;
            i_nxt      = '0;
            if (!meth_r) begin
              bank_nxt = ~bank_r;
            end
            if (big_new <= {1'b0, tol_r}) begin
              status_nxt = ils_pkg::ST_CONVERGED;
              state_nxt  = ils_pkg::S_EMIT_RD;
            end else if (sw_inc == maxit_r) begin
              status_nxt = ils_pkg::ST_LIMIT;
              state_nxt  = ils_pkg::S_EMIT_RD;
            end else begin
              big_nxt   = '0;
              state_nxt = ils_pkg::S_ROW;
            end
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = ils_pkg::S_ROW;
          end
        end
      end
      ils_pkg::S_EMIT_RD: begin
        if (!out_v_r) begin
          state_nxt = ils_pkg::S_EMIT_LD;
        end
      end
      ils_pkg::S_EMIT_LD: begin
        out_v_nxt    = 1'b1;
        out_idx_nxt  = 3'(i_r);
        out_sol_nxt  = x_val;
        out_st_nxt   = status_r;
        out_sw_nxt   = sweeps_r;
        out_last_nxt = (i_r == last_r);
        if (i_r == last_r) begin
          state_nxt = ils_pkg::S_IDLE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ils_pkg::S_EMIT_RD;
        end
      end
      default: state_nxt = ils_pkg::S_IDLE;
    endcase
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_sw_r, out_sol_r, out_idx_r};
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ils_pkg::S_DIV)
    else $error("divider finished outside the divide state");

  a_sweeps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ils_pkg::S_EMIT_RD || state_r == ils_pkg::S_EMIT_LD)
      |-> sweeps_r <= maxit_r)
    else $error("sweep count beyond iteration limit");

  a_mac_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    mul_v_r |-> (state_r == ils_pkg::S_ROW || state_r == ils_pkg::S_DRAIN))
    else $error("product pending outside row processing");

  a_drain_before_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (!rd_v_r && !mul_v_r))
    else $error("divide started with accumulation pending");

endmodule

// ===== rtl/ils_ram.sv =====
module ils_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ils_div.sv =====
module ils_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic signed [31:0] divisor,
  output logic               done,
  output logic signed [31:0] quotient
);

  localparam int CW = $clog2(ils_pkg::DIV_STEPS);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [63:0]   dvd_r, dvd_nxt;
  logic [63:0]   q_r, q_nxt;
  logic [31:0]   dsr_r, dsr_nxt;
  logic          neg_r, neg_nxt;
  logic [32:0]   sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    q_r   <= q_nxt;
    dsr_r <= dsr_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;
    sh       = {rem_r, dvd_r[63]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend[63] ? 64'(-dividend) : dividend;
      dsr_nxt  = divisor[31] ? 32'(-divisor) : divisor;
      neg_nxt  = dividend[63] ^ divisor[31];
      q_nxt    = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[62:0], 1'b0};
      if (sh >= {1'b0, dsr_r}) begin
        rem_nxt = 32'(sh - {1'b0, dsr_r});
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh[31:0];
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(ils_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    if (!neg_r) begin
      quotient = (q_r > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q_r[31:0];
    end else begin
      quotient = (q_r > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-q_r[31:0]);
    end
  end

  assign done = done_r;

endmodule
